>>> hw/rtl/mck_pkg.sv
// Package for the Morse character keyer: field types, state codes and the
// packed Morse code table. No dependencies.
`timescale 1ns / 1ps

package mck_pkg;

  typedef logic [7:0]  char_t;
  typedef logic [7:0]  code_t;
  typedef logic [2:0]  units_t;
  typedef logic [15:0] dot_len_t;
  typedef logic [18:0] dur_t;

  localparam int unsigned TableSize = 43;
  localparam char_t  CharSpace    = 8'h20;
  localparam char_t  CharFullStop = 8'h2E;
  localparam char_t  CharSlash    = 8'h2F;
  localparam char_t  CharFirst    = 8'h30;
  localparam char_t  CharLast     = 8'h5A;
  localparam code_t  CodeFullStop = 8'h95;
  localparam code_t  CodeSlash    = 8'hD2;
  localparam code_t  CodeUnknown  = 8'h8C;
  localparam dot_len_t DotLenReset = 16'd100;

  localparam units_t UnitsDot   = 3'd1;
  localparam units_t UnitsDash  = 3'd3;
  localparam units_t UnitsCharGap = 3'd2;
  localparam units_t UnitsWordGap = 3'd6;

  localparam code_t MORSE_TABLE [TableSize] = '{
    8'hDF, 8'hCF, 8'hC7, 8'hC3, 8'hC1, 8'hC0, 8'hD0, 8'hD8, 8'hDC, 8'hDE,
    8'hB8, 8'hAA, 8'h8C, 8'hD1, 8'h8C, 8'h8C, 8'h9A,
    8'hF9, 8'hE8, 8'hEA, 8'hF4, 8'hFC, 8'hE2, 8'hF6, 8'hE0, 8'hF8, 8'hE7,
    8'hF5, 8'hE4, 8'hFB, 8'hFA, 8'hF7, 8'hE6, 8'hED, 8'hF2, 8'hF0, 8'hFD,
    8'hF1, 8'hE1, 8'hF3, 8'hE9, 8'hEB, 8'hEC
  };

  // Maps a character to its packed code; unknown characters send '?'.
  function automatic code_t lookup_code(input char_t c);
    logic [5:0] idx;
    code_t      code;
    idx = 6'(c - CharFirst);
    if (c >= CharFirst && c <= CharLast) begin
      code = MORSE_TABLE[idx];
    end else if (c == CharFullStop) begin
      code = CodeFullStop;
    end else if (c == CharSlash) begin
      code = CodeSlash;
    end else begin
      code = CodeUnknown;
    end
    return code;
  endfunction

endpackage

>>> hw/rtl/mck_in_if.sv
// Character request channel of the Morse character keyer.
// Depends on mck_pkg.
`timescale 1ns / 1ps

interface mck_in_if;
  import mck_pkg::*;
  logic  valid;
  logic  ready;
  char_t character_code;
  modport source (output valid, output character_code, input ready);
  modport sink   (input valid, input character_code, output ready);
endinterface

>>> hw/rtl/mck_out_if.sv
// Key segment request channel of the Morse character keyer.
// Depends on mck_pkg.
`timescale 1ns / 1ps

interface mck_out_if;
  import mck_pkg::*;
  logic   valid;
  logic   ready;
  logic   key_on;
  units_t units;
  dur_t   duration;
  logic   last;
  modport source (output valid, output key_on, output units, output duration,
                  output last, input ready);
  modport sink   (input valid, input key_on, input units, input duration,
                  input last, output ready);
endinterface

>>> hw/rtl/mck_cfg_if.sv
// Dot length write channel of the Morse character keyer.
// Depends on mck_pkg.
`timescale 1ns / 1ps

interface mck_cfg_if;
  import mck_pkg::*;
  logic     valid;
  logic     ready;
  dot_len_t dot_length;
  modport source (output valid, output dot_length, input ready);
  modport sink   (input valid, input dot_length, output ready);
endinterface

>>> hw/rtl/morse_character_keyer.sv
// Morse character keyer: turns one ASCII character into a run of key segments.
// Depends on mck_pkg and the interfaces mck_in_if, mck_out_if and mck_cfg_if.
//
//  Channel | Direction | Payload                          | Request
//  in_ch   | sink      | character_code                   | one character
//  out_ch  | source    | key_on, units, duration, last    | one key segment
//  cfg_ch  | sink      | dot_length                       | one register write
//
// The code shifts out of a register: the skip state drops each leading one bit
// and the marker zero, then each element gives a keyed segment and its space
// while out_ch takes them, and a closing gap segment ends the character.
// rst_n is synchronous; it clears the sequencer and sets dot_length to 100.
// A stalled out_ch holds the segment states, not the skip; in_ch is ready whenever the sequencer is idle.
`timescale 1ns / 1ps

module morse_character_keyer (
  input logic clk,
  input logic rst_n,
  mck_in_if.sink    in_ch,
  mck_out_if.source out_ch,
  mck_cfg_if.sink   cfg_ch
);
  import mck_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SKIP = 3'd1;
  localparam logic [2:0] S_ON   = 3'd2;
  localparam logic [2:0] S_OFF  = 3'd3;
  localparam logic [2:0] S_GAP  = 3'd4;

  logic [2:0] state_r, state_nxt;
  code_t      code_r, code_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       space_r, space_nxt;
  dot_len_t   dot_len_r;

  logic   out_valid_r;
  logic   key_on_r;
  units_t units_r;
  dur_t   duration_r;
  logic   last_r;

  logic   adv;
  logic   load;
  logic   seg_on;
  units_t seg_units;
  logic   seg_last;
  dur_t   seg_dur;
  dur_t   d19;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign adv = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cnt_nxt   = cnt_r;
    space_nxt = space_r;
    load      = 1'b0;
    seg_on    = 1'b0;
    seg_units = UnitsCharGap;
    seg_last  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          code_nxt  = lookup_code(in_ch.character_code);
          cnt_nxt   = 4'd8;
          space_nxt = (in_ch.character_code == CharSpace);
          state_nxt = (in_ch.character_code == CharSpace) ? S_GAP : S_SKIP;
        end
      end
      S_SKIP: begin
        if (cnt_r == 4'd0) begin
          state_nxt = S_GAP;
        end else begin
          code_nxt = {code_r[6:0], 1'b0};
          cnt_nxt  = cnt_r - 4'd1;
          if (!code_r[7]) begin
            state_nxt = (cnt_r == 4'd1) ? S_GAP : S_ON;
          end
        end
      end
      S_ON: begin
        if (adv) begin
          load      = 1'b1;
          seg_on    = 1'b1;
          seg_units = code_r[7] ? UnitsDash : UnitsDot;
          state_nxt = S_OFF;
        end
      end
      S_OFF: begin
        if (adv) begin
          load      = 1'b1;
          seg_units = UnitsDot;
          code_nxt  = {code_r[6:0], 1'b0};
          cnt_nxt   = cnt_r - 4'd1;
          state_nxt = (cnt_r == 4'd1) ? S_GAP : S_ON;
        end
      end
      S_GAP: begin
        if (adv) begin
          load      = 1'b1;
          seg_units = space_r ? UnitsWordGap : UnitsCharGap;
          seg_last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Units are at most 6, so the product is three gated shifted adds.
  assign d19 = 19'(dot_len_r);
  assign seg_dur = (seg_units[0] ? d19 : '0) + (seg_units[1] ? (d19 << 1) : '0)
                 + (seg_units[2] ? (d19 << 2) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      space_r     <= 1'b0;
      dot_len_r   <= DotLenReset;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      space_r <= space_nxt;
      if (cfg_ch.valid) begin
        dot_len_r <= cfg_ch.dot_length;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    if (load) begin
      key_on_r   <= seg_on;
      units_r    <= seg_units;
      duration_r <= seg_dur;
      last_r     <= seg_last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.key_on   = key_on_r;
  assign out_ch.units    = units_r;
  assign out_ch.duration = duration_r;
  assign out_ch.last     = last_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != S_IDLE))
    else $error("accepted character did not start the sequencer");

  a_last_ends_char: assert property (@(posedge clk) disable iff (!rst_n)
    (load && seg_last) |=> (state_r == S_IDLE))
    else $error("closing gap did not return the sequencer to idle");

  a_units_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (units_r == UnitsDot || units_r == UnitsCharGap ||
                     units_r == UnitsDash || units_r == UnitsWordGap))
    else $error("segment carries an illegal unit count");

  a_on_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ON || state_r == S_OFF) |-> (cnt_r != 4'd0))
    else $error("element state entered with no code bits left");

  a_on_then_off: assert property (@(posedge clk) disable iff (!rst_n)
    (load && seg_on) |=> (state_r == S_OFF))
    else $error("keyed segment not followed by its space");

endmodule

>>> test/morse_character_keyer_tb.sv
// Testbench for morse_character_keyer: drives characters and dot lengths and
// checks every key segment against a predictor kept in this file.
// Depends on mck_pkg and the interfaces mck_in_if, mck_out_if and mck_cfg_if.
`timescale 1ns / 1ps

module morse_character_keyer_tb;
  import mck_pkg::*;

  typedef struct packed {
    logic   key_on;
    units_t units;
    dur_t   duration;
    logic   last;
  } key_segment_t;

  localparam code_t KEY_CODES [TableSize] = '{
    8'hDF, 8'hCF, 8'hC7, 8'hC3, 8'hC1, 8'hC0, 8'hD0, 8'hD8, 8'hDC, 8'hDE,
    8'hB8, 8'hAA, 8'h8C, 8'hD1, 8'h8C, 8'h8C, 8'h9A,
    8'hF9, 8'hE8, 8'hEA, 8'hF4, 8'hFC, 8'hE2, 8'hF6, 8'hE0, 8'hF8, 8'hE7,
    8'hF5, 8'hE4, 8'hFB, 8'hFA, 8'hF7, 8'hE6, 8'hED, 8'hF2, 8'hF0, 8'hFD,
    8'hF1, 8'hE1, 8'hF3, 8'hE9, 8'hEB, 8'hEC
  };

  localparam char_t OPENING_CHARS [25] = '{
    CharSpace, CharFullStop, CharSlash, CharFirst, 8'h35, 8'h39, 8'h3A, 8'h3B,
    8'h3C, 8'h3D, 8'h3F, 8'h40, 8'h41, 8'h45, 8'h54, 8'h51, 8'h59, CharLast,
    8'h5B, 8'h00, 8'hFF, 8'h7F, 8'h61, 8'h80, 8'h2D
  };

  logic clk;
  logic rst_n;

  mck_in_if  chars_if ();
  mck_out_if keys_if ();
  mck_cfg_if dot_if ();

  morse_character_keyer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (chars_if),
    .out_ch (keys_if),
    .cfg_ch (dot_if)
  );

  char_t        chars_to_send [$];
  key_segment_t segments_due [$];
  dot_len_t     dot_len_now;
  logic         steady_run;
  int unsigned  fault_count;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void add_segment(logic on, units_t u, logic is_last);
    key_segment_t s;
    s.key_on   = on;
    s.units    = u;
    s.duration = dur_t'(32'(u) * 32'(dot_len_now));
    s.last     = is_last;
    segments_due.push_back(s);
  endfunction

  function automatic void predict_keying(char_t c);
    code_t code;
    int    top;
    int    b;
    if (c == CharSpace) begin
      add_segment(1'b0, UnitsWordGap, 1'b1);
      return;
    end
    if (c >= CharFirst && c < CharFirst + TableSize) begin
      code = KEY_CODES[c - CharFirst];
    end else if (c == CharFullStop) begin
      code = CodeFullStop;
    end else if (c == CharSlash) begin
      code = CodeSlash;
    end else begin
      code = CodeUnknown;
    end
    top = 7;
    while (top >= 0 && code[top]) top--;
    for (b = top - 1; b >= 0; b--) begin
      add_segment(1'b1, code[b] ? UnitsDash : UnitsDot, 1'b0);
      add_segment(1'b0, UnitsDot, 1'b0);
    end
    add_segment(1'b0, UnitsCharGap, 1'b1);
  endfunction

  function automatic char_t pick_character();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return char_t'(CharFirst + $urandom_range(0, TableSize - 1));
    end else if (r < 67) begin
      case ($urandom_range(0, 2))
        0: return CharSpace;
        1: return CharFullStop;
        default: return CharSlash;
      endcase
    end else if (r < 75) begin
      return char_t'($urandom_range(8'h5B, 8'h7F));
    end
    return char_t'($urandom_range(0, 255));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      chars_if.valid <= 1'b0;
    end else begin
      if (chars_if.valid && chars_if.ready) predict_keying(chars_if.character_code);
      if (!chars_if.valid || chars_if.ready) begin
        if (chars_to_send.size() != 0 && (steady_run || $urandom_range(0, 99) >= 24)) begin
          chars_if.valid          <= 1'b1;
          chars_if.character_code <= chars_to_send.pop_front();
        end else begin
          chars_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_segments
    key_segment_t got;
    key_segment_t want;
    if (!rst_n) begin
      keys_if.ready <= 1'b0;
    end else begin
      keys_if.ready <= steady_run || $urandom_range(0, 99) >= 24;
      if (keys_if.valid && keys_if.ready) begin
        got = '{keys_if.key_on, keys_if.units, keys_if.duration, keys_if.last};
        if (segments_due.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: unexpected segment key_on=%0d units=%0d duration=%0d last=%0d",
                     $time, got.key_on, got.units, got.duration, got.last);
        end else begin
          want = segments_due.pop_front();
          if (got.key_on !== want.key_on || got.units !== want.units ||
              got.duration !== want.duration || got.last !== want.last) begin
            fault_count++;
            if (fault_count <= 10)
              $display("%0t: expected key_on=%0d units=%0d duration=%0d last=%0d, got %0d %0d %0d %0d",
                       $time, want.key_on, want.units, want.duration, want.last,
                       got.key_on, got.units, got.duration, got.last);
          end
        end
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (chars_to_send.size() != 0 || chars_if.valid || segments_due.size() != 0);
  endtask

  task automatic write_dot_length(dot_len_t v);
    @(posedge clk);
    dot_if.valid      <= 1'b1;
    dot_if.dot_length <= v;
    do @(posedge clk);
    while (!dot_if.ready);
    dot_len_now = v;
    dot_if.valid <= 1'b0;
  endtask

  task automatic send_random(int n);
    @(negedge clk);
    repeat (n) chars_to_send.push_back(pick_character());
    wait_drained();
  endtask

  initial begin
    rst_n                   = 1'b0;
    chars_if.valid          = 1'b0;
    chars_if.character_code = '0;
    keys_if.ready           = 1'b0;
    dot_if.valid            = 1'b0;
    dot_if.dot_length       = '0;
    steady_run              = 1'b0;
    fault_count             = 0;
    dot_len_now             = DotLenReset;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    foreach (OPENING_CHARS[i]) chars_to_send.push_back(OPENING_CHARS[i]);
    wait_drained();
    repeat (20) @(posedge clk);

    write_dot_length(16'd1);
    send_random(95);
    write_dot_length(16'hFFFF);
    send_random(95);
    write_dot_length(dot_len_t'($urandom_range(2, 16'hFFFE)));
    @(negedge clk);
    steady_run = 1'b1;
    send_random(90);
    steady_run = 1'b0;
    write_dot_length(dot_len_t'($urandom_range(1, 16'hFFFF)));
    send_random(90);
    write_dot_length(DotLenReset);
    send_random(90);

    repeat (30) @(posedge clk);
    if (fault_count == 0) begin
      $display("morse_character_keyer_tb: PASS");
    end else begin
      $display("morse_character_keyer_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("morse_character_keyer_tb: FAIL");
    $finish;
  end

endmodule
